// ===== design/cwc_pkg.sv =====
// Shared types and constants for the conductance waveform clamp.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package cwc_pkg;

    localparam int OP_W       = 2;
    localparam int VM_W       = 16;
    localparam int ADDR_W     = 12;
    localparam int SAMPLE_W   = 24;
    localparam int CMD_W      = 40;
    localparam int POS_W      = 17;
    localparam int COUNT_W    = 16;
    localparam int TRIAL_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int LEN_W      = 13;
    localparam int DG_W       = 34;
    localparam int PROD_W     = 58;

    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REVERSAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 3'd5;

    localparam logic signed [CMD_W-1:0] CMD_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [CMD_W-1:0] CMD_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic tick_start;
        logic load_write;
        logic restart;
        logic mult_en;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== design/cwc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the waveform samples of the clamp.
`timescale 1ns / 1ps

module cwc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/cwc_ctrl.sv =====
// Controller state machine of the conductance waveform clamp.
// Decides when words are accepted and sequences the datapath; uses cwc_pkg.
`timescale 1ns / 1ps

module cwc_ctrl
    import cwc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OP_W-1:0]  operation,
    input  ctrl_status_t     status,
    output ctrl_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   can_take;
    logic   accept;

    always_comb
    begin
        can_take = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && status.out_free);
        accept   = in_valid && can_take;

        cmd.tick_start = accept && (operation == OP_TICK);
        cmd.load_write = accept && (operation == OP_LOAD);
        cmd.restart    = accept && (operation == OP_RESTART);
        cmd.mult_en    = (state_reg == ST_MULT);
        cmd.out_load   = (state_reg == ST_FINISH) && status.out_free;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.tick_start)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = cmd.tick_start ? ST_MULT : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = can_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/cwc_dpath.sv =====
// Datapath of the conductance waveform clamp: settings, trial counters,
// waveform store, the two multiply stages and the output register. Uses cwc_pkg and cwc_ram.
`timescale 1ns / 1ps

module cwc_dpath
    import cwc_pkg::*;
#(
    parameter int WAVE_DEPTH = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctrl_cmd_t                   cmd,
    output ctrl_status_t                status,
    input  logic                        cfg_valid,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [VM_W-1:0]      membrane_voltage,
    input  logic                        spike_seen,
    input  logic [ADDR_W-1:0]           load_address,
    input  logic signed [SAMPLE_W-1:0]  load_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [CMD_W-1:0]     command_current,
    output logic                        spike_mark,
    output logic [POS_W-1:0]            spike_offset,
    output logic [TRIAL_W-1:0]          trial_number,
    output logic                        done_res
);

    localparam int                AW        = $clog2(WAVE_DEPTH);
    localparam logic [POS_W-1:0]  DEPTH_EXT = POS_W'(WAVE_DEPTH);

    logic signed [VM_W-1:0]     reversal_reg;
    logic [15:0]                gain_reg;
    logic [LEN_W-1:0]           length_reg;
    logic [15:0]                wait_reg;
    logic signed [SAMPLE_W-1:0] hold_reg;
    logic [COUNT_W-1:0]         repeat_reg;

    logic [POS_W-1:0]           position_reg;
    logic [COUNT_W-1:0]         count_reg;

    logic signed [DG_W-1:0]     dg_reg;
    logic                       use_store_reg;
    logic                       meta_spike_reg;
    logic [POS_W-1:0]           meta_offset_reg;
    logic [TRIAL_W-1:0]         meta_trial_reg;
    logic                       meta_done_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    logic                       out_valid_reg;
    logic signed [CMD_W-1:0]    command_reg;
    logic                       spike_mark_reg;
    logic [POS_W-1:0]           spike_offset_reg;
    logic [TRIAL_W-1:0]         trial_number_reg;
    logic                       done_reg;

    logic [POS_W-1:0]           eff_len;
    logic [POS_W-1:0]           period_raw;
    logic [POS_W-1:0]           period;
    logic                       done_now;
    logic [POS_W:0]             pos_inc;
    logic                       wrap;
    logic [COUNT_W-1:0]         count_next;
    logic [POS_W-1:0]           position_next;
    logic signed [POS_W-1:0]    diff;
    logic signed [DG_W-1:0]     dg_next;
    logic [POS_W-1:0]           load_addr_ext;
    logic                       load_in_range;
    logic signed [SAMPLE_W-1:0] ram_rdata;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   neg_prod;
    logic signed [PROD_W-9:0]   shifted;
    logic signed [CMD_W-1:0]    saturated;
    logic signed [CMD_W-1:0]    command_next;

    always_comb
    begin
        eff_len    = (POS_W'(length_reg) < DEPTH_EXT) ? POS_W'(length_reg) : DEPTH_EXT;
        period_raw = eff_len + POS_W'(wait_reg);
        period     = (period_raw == '0) ? POS_W'(1) : period_raw;
        done_now   = count_reg >= repeat_reg;
        pos_inc    = {1'b0, position_reg} + (POS_W + 1)'(1);
        wrap       = pos_inc >= {1'b0, period};

        count_next    = count_reg;
        position_next = position_reg;
        if (cmd.restart)
        begin
            count_next    = '0;
            position_next = '0;
        end
        else if (cmd.tick_start && !done_now)
        begin
            if (wrap)
            begin
                count_next    = count_reg + COUNT_W'(1);
                position_next = '0;
            end
            else
            begin
                position_next = pos_inc[POS_W-1:0];
            end
        end

        diff    = {membrane_voltage[VM_W-1], membrane_voltage}
                - {reversal_reg[VM_W-1], reversal_reg};
        dg_next = diff * $signed({1'b0, gain_reg});

        load_addr_ext = POS_W'(load_address);
        load_in_range = load_addr_ext < DEPTH_EXT;

        sample    = use_store_reg ? ram_rdata : hold_reg;
        prod_next = sample * dg_reg;

        neg_prod = -prod_reg;
        shifted  = neg_prod[PROD_W-1:8];
        if (shifted[PROD_W-9:CMD_W-1] != {(PROD_W-8-CMD_W+1){shifted[PROD_W-9]}})
        begin
            saturated = shifted[PROD_W-9] ? CMD_MIN : CMD_MAX;
        end
        else
        begin
            saturated = shifted[CMD_W-1:0];
        end
        command_next = meta_done_reg ? '0 : saturated;
    end

    cwc_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(WAVE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load_write && load_in_range),
        .waddr (load_addr_ext[AW-1:0]),
        .wdata (load_sample),
        .re    (cmd.tick_start),
        .raddr (position_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reversal_reg  <= -16'sd7000;
            gain_reg      <= 16'd256;
            length_reg    <= 13'd4096;
            wait_reg      <= '0;
            hold_reg      <= '0;
            repeat_reg    <= 16'd1;
            position_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_REVERSAL: reversal_reg <= cfg_data[VM_W-1:0];
                    CFG_GAIN:     gain_reg     <= cfg_data[15:0];
                    CFG_LENGTH:   length_reg   <= cfg_data[LEN_W-1:0];
                    CFG_WAIT:     wait_reg     <= cfg_data[15:0];
                    CFG_HOLD:     hold_reg     <= cfg_data[SAMPLE_W-1:0];
                    CFG_REPEAT:   repeat_reg   <= cfg_data[COUNT_W-1:0];
                    default:      ;
                endcase
            end
            position_reg <= position_next;
            count_reg    <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_start)
        begin
            dg_reg          <= dg_next;
            use_store_reg   <= position_reg < eff_len;
            meta_spike_reg  <= spike_seen;
            meta_offset_reg <= spike_seen ? position_reg : '0;
            meta_trial_reg  <= TRIAL_W'(count_next) + TRIAL_W'(1);
            meta_done_reg   <= done_now;
        end
        if (cmd.mult_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load)
        begin
            command_reg      <= command_next;
            spike_mark_reg   <= meta_spike_reg;
            spike_offset_reg <= meta_offset_reg;
            trial_number_reg <= meta_trial_reg;
            done_reg         <= meta_done_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign command_current = command_reg;
    assign spike_mark      = spike_mark_reg;
    assign spike_offset    = spike_offset_reg;
    assign trial_number    = trial_number_reg;
    assign done_res        = done_reg;

endmodule

// ===== design/conductance_waveform_clamp.sv =====
// Conductance waveform clamp: plays a stored conductance waveform as a
// command current over repeated trials. Top level; uses cwc_pkg, cwc_ctrl and cwc_dpath.
//
// Usage:
// The input channel (in_valid/in_ready) carries one word per item: a tick with
// the membrane voltage and spike flag, a waveform sample load, or a restart.
// Each tick word yields exactly one result word on the output channel
// (out_valid/out_ready); load and restart words yield none.
// Settings must be written through the cfg channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data), always ready, only while no tick is in flight; the block does not enforce this.
// A tick's result is built in order: the store read and the voltage-by-gain
// multiply complete at the accepting edge, then the sample multiply, then
// negation, scaling and saturation into the output register. The next word
// is taken in the cycle the result is registered, so a new tick waits for the
// one before it; loads and restarts leave the controller idle. A stalled
// receiver holds the result in the output register; the input is accepted
// again once that register can be refilled.
// Reset restores the default settings and clears the trial position and
// count; the waveform store keeps no reset value and must be loaded.
`timescale 1ns / 1ps

module conductance_waveform_clamp
    import cwc_pkg::*;
#(
    parameter int WAVE_DEPTH = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [OP_W-1:0]             operation,
    input  logic signed [VM_W-1:0]      membrane_voltage,
    input  logic                        spike_seen,
    input  logic [ADDR_W-1:0]           load_address,
    input  logic signed [SAMPLE_W-1:0]  load_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [CMD_W-1:0]     command_current,
    output logic                        spike_mark,
    output logic [POS_W-1:0]            spike_offset,
    output logic [TRIAL_W-1:0]          trial_number,
    output logic                        done_res,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    cwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    cwc_dpath #(
        .WAVE_DEPTH(WAVE_DEPTH)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .membrane_voltage (membrane_voltage),
        .spike_seen       (spike_seen),
        .load_address     (load_address),
        .load_sample      (load_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .command_current  (command_current),
        .spike_mark       (spike_mark),
        .spike_offset     (spike_offset),
        .trial_number     (trial_number),
        .done_res         (done_res)
    );

endmodule

// ===== bench/cwc_checker.sv =====
// Checker for the conductance waveform clamp: watches the settings, input and result channels,
// predicts each tick's result word and compares it with what the block returns.
// Depends on cwc_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 1ps

module cwc_checker
    import cwc_pkg::*;
#(
    parameter int WAVE_DEPTH = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [OP_W-1:0]             operation,
    input  logic signed [VM_W-1:0]      membrane_voltage,
    input  logic                        spike_seen,
    input  logic [ADDR_W-1:0]           load_address,
    input  logic signed [SAMPLE_W-1:0]  load_sample,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [CMD_W-1:0]     command_current,
    input  logic                        spike_mark,
    input  logic [POS_W-1:0]            spike_offset,
    input  logic [TRIAL_W-1:0]          trial_number,
    input  logic                        done_res,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output int                          fail_count,
    output int                          pending,
    output logic                        needs_load,
    output logic [ADDR_W-1:0]           needed_addr
);

    typedef struct packed {
        logic signed [CMD_W-1:0] current;
        logic                    mark;
        logic [POS_W-1:0]        offset;
        logic [TRIAL_W-1:0]      trial;
        logic                    done;
    } clamp_word_t;

    logic signed [VM_W-1:0]     reversal_mv;
    logic [15:0]                gain_q8;
    logic [LEN_W-1:0]           wave_len;
    logic [15:0]                dwell_len;
    logic signed [SAMPLE_W-1:0] hold_g;
    logic [COUNT_W-1:0]         trials_max;

    logic signed [SAMPLE_W-1:0] wave [WAVE_DEPTH];
    logic [WAVE_DEPTH-1:0]      loaded;
    logic [POS_W-1:0]           position;
    logic [COUNT_W-1:0]         trials;

    clamp_word_t expected_words[$];

    function automatic int play_length();
        return (int'(wave_len) < WAVE_DEPTH) ? int'(wave_len) : WAVE_DEPTH;
    endfunction

    function automatic logic signed [CMD_W-1:0] clamp_current(
        logic signed [SAMPLE_W-1:0] g,
        logic signed [VM_W-1:0]     vm
    );
        longint drive;
        longint charge;
        longint scaled;
        drive  = longint'(vm) - longint'(reversal_mv);
        charge = -(longint'(g) * drive * longint'(gain_q8));
        scaled = charge >>> 8;
        if (scaled > longint'(CMD_MAX))
            return CMD_MAX;
        if (scaled < longint'(CMD_MIN))
            return CMD_MIN;
        return scaled[CMD_W-1:0];
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_REVERSAL: reversal_mv = data[VM_W-1:0];
            CFG_GAIN:     gain_q8     = data[15:0];
            CFG_LENGTH:   wave_len    = data[LEN_W-1:0];
            CFG_WAIT:     dwell_len   = data[15:0];
            CFG_HOLD:     hold_g      = data[SAMPLE_W-1:0];
            CFG_REPEAT:   trials_max  = data[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void play_tick(logic signed [VM_W-1:0] vm, logic spike);
        clamp_word_t                word;
        int                         len;
        int                         period;
        logic                       finished;
        logic signed [SAMPLE_W-1:0] g;
        len    = play_length();
        period = len + int'(dwell_len);
        if (period == 0)
            period = 1;
        finished     = (trials >= trials_max);
        word.current = '0;
        word.mark    = spike;
        word.offset  = spike ? position : '0;
        if (!finished)
        begin
            g = (int'(position) < len) ? wave[position[ADDR_W-1:0]] : hold_g;
            word.current = clamp_current(g, vm);
            if (int'(position) + 1 >= period)
            begin
                position = '0;
                trials   = trials + 1'b1;
            end
            else
            begin
                position = position + 1'b1;
            end
        end
        word.trial = {1'b0, trials} + 1'b1;
        word.done  = finished;
        expected_words.insert(expected_words.size(), word);
    endfunction

    function automatic void check_word();
        clamp_word_t want;
        if (expected_words.size() == 0)
        begin
            $error("result word with no tick outstanding: command_current %0d", command_current);
            fail_count++;
            return;
        end
        want = expected_words.pop_front();
        if (command_current !== want.current)
        begin
            $error("command_current: expected %0d, got %0d", want.current, command_current);
            fail_count++;
        end
        if (spike_mark !== want.mark)
        begin
            $error("spike_mark: expected %0d, got %0d", want.mark, spike_mark);
            fail_count++;
        end
        if (spike_offset !== want.offset)
        begin
            $error("spike_offset: expected %0d, got %0d", want.offset, spike_offset);
            fail_count++;
        end
        if (trial_number !== want.trial)
        begin
            $error("trial_number: expected %0d, got %0d", want.trial, trial_number);
            fail_count++;
        end
        if (done_res !== want.done)
        begin
            $error("done_res: expected %0d, got %0d", want.done, done_res);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reversal_mv = -16'sd7000;
            gain_q8     = 16'd256;
            wave_len    = 13'd4096;
            dwell_len   = '0;
            hold_g      = '0;
            trials_max  = 16'd1;
            loaded      = '0;
            position    = '0;
            trials      = '0;
            fail_count  = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_setting(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                case (operation)
                    OP_TICK:
                        play_tick(membrane_voltage, spike_seen);
                    OP_LOAD:
                    begin
                        if (int'(load_address) < WAVE_DEPTH)
                        begin
                            wave[load_address]   = load_sample;
                            loaded[load_address] = 1'b1;
                        end
                    end
                    OP_RESTART:
                    begin
                        position = '0;
                        trials   = '0;
                    end
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                check_word();
        end
        pending     = expected_words.size();
        needed_addr = position[ADDR_W-1:0];
        needs_load  = 1'b0;
        if (trials < trials_max && int'(position) < play_length())
            needs_load = !loaded[position[ADDR_W-1:0]];
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the conductance waveform clamp testbench: clock, reset, stimulus and verdict.
// Depends on cwc_pkg, the block conductance_waveform_clamp and the checker cwc_checker.
`timescale 1ns / 1ps

module tb_top;
    import cwc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 140;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 1000000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [OP_W-1:0]            operation;
    logic signed [VM_W-1:0]     membrane_voltage;
    logic                       spike_seen;
    logic [ADDR_W-1:0]          load_address;
    logic signed [SAMPLE_W-1:0] load_sample;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [CMD_W-1:0]    command_current;
    logic                       spike_mark;
    logic [POS_W-1:0]           spike_offset;
    logic [TRIAL_W-1:0]         trial_number;
    logic                       done_res;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int                         fail_count;
    int                         pending;
    logic                       needs_load;
    logic [ADDR_W-1:0]          needed_addr;

    bit                         steady;
    bit                         hold_req;
    int                         cycles = 0;

    conductance_waveform_clamp i_dut (.*);

    cwc_checker i_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VM_W-1:0] pick_voltage();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return '0;
            default: return VM_W'($urandom());
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'hFFFFFF;
            3: return '0;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Receiver: random stalls, or one long hold-off when asked for.
    initial
    begin
        int stall;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                stall = steady ? 0 : idle_span();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(
        logic [OP_W-1:0]     op,
        logic [VM_W-1:0]     vm,
        logic                spike,
        logic [ADDR_W-1:0]   addr,
        logic [SAMPLE_W-1:0] sample
    );
        int gap;
        in_valid         <= 1'b1;
        operation        <= op;
        membrane_voltage <= vm;
        spike_seen       <= spike;
        load_address     <= addr;
        load_sample      <= sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        gap = steady ? 0 : idle_span();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // A tick never reads a store entry that was never loaded: fill it first.
    task automatic send_tick(logic [VM_W-1:0] vm, logic spike);
        if (needs_load)
            send_word(OP_LOAD, pick_voltage(), 1'($urandom()), needed_addr, pick_sample());
        send_word(OP_TICK, vm, spike, ADDR_W'($urandom()), pick_sample());
    endtask

    task automatic send_random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            send_tick(pick_voltage(), 1'($urandom()));
        else if (r < 88)
            send_word(OP_LOAD, pick_voltage(), 1'($urandom()),
                      ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom())
                                                  : ADDR_W'($urandom_range(0, 63)),
                      pick_sample());
        else if (r < 95)
            send_word(OP_RESTART, pick_voltage(), 1'($urandom()), ADDR_W'($urandom()),
                      pick_sample());
        else
            send_word(OP_UNUSED, pick_voltage(), 1'($urandom()), ADDR_W'($urandom()),
                      pick_sample());
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_settings(
        logic [15:0]         rev,
        logic [15:0]         g,
        logic [LEN_W-1:0]    len,
        logic [15:0]         dwell,
        logic [SAMPLE_W-1:0] hold,
        logic [15:0]         trials_max
    );
        logic [CFG_IDX_W-1:0]  slot [6];
        logic [CFG_DATA_W-1:0] value [6];
        int                    i;
        slot  = '{CFG_REVERSAL, CFG_GAIN, CFG_LENGTH, CFG_WAIT, CFG_HOLD, CFG_REPEAT};
        value = '{CFG_DATA_W'(rev), CFG_DATA_W'(g), CFG_DATA_W'(len), CFG_DATA_W'(dwell),
                  CFG_DATA_W'(hold), CFG_DATA_W'(trials_max)};
        settle();
        for (i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= slot[i];
            cfg_data  <= value[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic phase_settings(int phase);
        logic [15:0]         rev;
        logic [15:0]         g;
        logic [LEN_W-1:0]    len;
        logic [15:0]         dwell;
        logic [SAMPLE_W-1:0] hold;
        logic [15:0]         trials_max;
        int                  r;
        rev   = ($urandom_range(0, 3) == 0) ? 16'h8000 : 16'($urandom());
        g     = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom());
        hold  = pick_sample();
        r     = $urandom_range(0, 99);
        len   = (r < 70) ? LEN_W'($urandom_range(0, 48))
              : (r < 85) ? 13'd4096 : LEN_W'($urandom());
        r     = $urandom_range(0, 99);
        dwell = (r < 60) ? 16'($urandom_range(0, 16)) : (r < 80) ? 16'd0 : 16'($urandom());
        r     = $urandom_range(0, 99);
        trials_max = (r < 70) ? 16'($urandom_range(1, 4))
                   : (r < 80) ? 16'd0 : (r < 90) ? 16'hFFFF : 16'($urandom());
        case (phase)
            0: write_settings(16'h7FFF, 16'hFFFF, 13'h1FFF, 16'hFFFF, 24'h7FFFFF, 16'hFFFF);
            1: write_settings(16'h8000, 16'h0000, 13'h0000, 16'h0000, 24'h800000, 16'h0000);
            2: write_settings(16'h8000, 16'hFFFF, 13'd1, 16'd0, 24'h7FFFFF, 16'hFFFF);
            3: write_settings(rev, g, 13'd0, 16'd2, hold, 16'd3);
            default: write_settings(rev, g, len, dwell, hold, trials_max);
        endcase
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        operation        <= OP_TICK;
        membrane_voltage <= '0;
        spike_seen       <= 1'b0;
        load_address     <= '0;
        load_sample      <= '0;
        out_ready        <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_index        <= CFG_REVERSAL;
        cfg_data         <= '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: full-length waveform, one trial, no wait.
        send_word(OP_LOAD, '0, 1'b0, 12'd0, 24'h7FFFFF);
        send_word(OP_LOAD, '0, 1'b1, 12'd1, 24'h800000);
        send_word(OP_LOAD, '0, 1'b0, 12'd2, 24'hFFFFFF);
        send_word(OP_LOAD, '0, 1'b0, 12'd3, 24'h000000);
        send_word(OP_LOAD, '0, 1'b0, 12'hFFF, 24'h123456);
        send_tick(16'h7FFF, 1'b1);
        send_tick(16'h8000, 1'b0);
        send_tick(-16'sd7000, 1'b1);
        send_tick(16'h0000, 1'b0);
        send_word(OP_RESTART, 16'h7FFF, 1'b1, 12'hFFF, 24'hFFFFFF);
        send_word(OP_UNUSED, 16'h7FFF, 1'b1, 12'hFFF, 24'hFFFFFF);
        send_tick(16'd1234, 1'b1);

        // Two short trials with a wait tick, driven into saturation, then past the end.
        write_settings(16'h8000, 16'hFFFF, 13'd2, 16'd1, 24'h7FFFFF, 16'd2);
        send_tick(16'h7FFF, 1'b1);
        send_tick(16'h7FFF, 1'b0);
        send_tick(16'h0000, 1'b1);
        send_tick(16'h8000, 1'b0);
        send_tick(16'h7FFF, 1'b1);
        send_tick(16'h7FFF, 1'b0);
        send_tick(16'h8000, 1'b1);
        send_word(OP_RESTART, '0, 1'b0, '0, '0);
        send_tick(16'h8001, 1'b1);

        // Shrink the trial below the current position; small negative values must round down.
        write_settings(16'h0000, 16'd1, 13'd0, 16'd0, 24'hFFFFFF, 16'd3);
        send_tick(16'hFFFF, 1'b1);
        send_tick(16'd255, 1'b0);
        send_tick(-16'sd257, 1'b1);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            phase_settings(phase);
            steady = (phase % 3 == 2);
            if (phase == 4)
                hold_req = 1'b1;
            for (n = 0; n < WORDS_PER_PHASE; n++)
                send_random_word();
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
